// ----- hdl/gti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gti_pkg
// Constants and GF(2^8) composite-field arithmetic for the tower-field
// inverter: basis change matrices and the GF(4)/GF(16)/GF(256) primitives.
// ----------------------------------------------------------------------------
package gti_pkg;

  localparam int unsigned ByteW = 8;

  // Polynomial basis reduction polynomial x^8+x^4+x^3+x+1 (implied by the
  // matrices below, kept for reference)
  localparam logic [8:0] FIELD_POLY = 9'h11B;

  // Extension coefficients: GF(16) over GF(4), GF(256) over GF(16)
  localparam logic [1:0] NU_COEF     = 2'h2;
  localparam logic [3:0] LAMBDA_COEF = 4'h1;

  // Basis change matrices, row r at [r]
  localparam logic [7:0][7:0] TO_TOWER = {
    8'hff, 8'ha9, 8'h81, 8'h09, 8'h48, 8'hf2, 8'hf3, 8'h98
  };
  localparam logic [7:0][7:0] FROM_TOWER = {
    8'h60, 8'hde, 8'h29, 8'h68, 8'h8c, 8'h6e, 8'h78, 8'h64
  };

  // Bit k of the operand selects row 7-k; selected rows are XORed
  function automatic logic [7:0] map_basis(input logic [7:0] v,
                                           input logic [7:0][7:0] rows);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) acc = acc ^ rows[7 - k];
    end
    return acc;
  endfunction

  // GF(4), normal basis
  function automatic logic [1:0] mul4(input logic [1:0] x, input logic [1:0] y);
    logic e;
    e = (x[1] ^ x[0]) & (y[1] ^ y[0]);
    return {(x[1] & y[1]) ^ e, (x[0] & y[0]) ^ e};
  endfunction

  // GF(16) over GF(4), normal basis
  function automatic logic [3:0] mul16(input logic [3:0] x, input logic [3:0] y);
    logic [1:0] e;
    e = mul4(mul4(x[3:2] ^ x[1:0], y[3:2] ^ y[1:0]), NU_COEF);
    return {mul4(x[3:2], y[3:2]) ^ e, mul4(x[1:0], y[1:0]) ^ e};
  endfunction

  // GF(16) inverse via GF(4) (inverse in GF(4) is squaring)
  function automatic logic [3:0] inv16(input logic [3:0] x);
    logic [1:0] s;
    logic [1:0] t;
    logic [1:0] e;
    s = x[3:2] ^ x[1:0];
    t = mul4(mul4(s, s), NU_COEF) ^ mul4(x[3:2], x[1:0]);
    e = mul4(t, t);
    return {mul4(e, x[1:0]), mul4(e, x[3:2])};
  endfunction

  // GF(256) over GF(16), normal basis
  function automatic logic [7:0] inv256(input logic [7:0] x);
    logic [3:0] s;
    logic [3:0] e;
    s = x[7:4] ^ x[3:0];
    e = inv16(mul16(mul16(s, s), LAMBDA_COEF) ^ mul16(x[7:4], x[3:0]));
    return {mul16(e, x[3:0]), mul16(e, x[7:4])};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/gti_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gti_in_if
// Input channel: one polynomial-basis byte per transfer.
// ----------------------------------------------------------------------------
interface gti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface
`default_nettype wire

// ----- hdl/gti_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gti_out_if
// Output channel: one inverse byte per transfer.
// ----------------------------------------------------------------------------
interface gti_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] inverse_out;

  modport source (output valid, output inverse_out, input ready);
  modport sink   (input valid, input inverse_out, output ready);
endinterface
`default_nettype wire

// ----- hdl/gti_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gti_core
// Combinational datapath: map into the tower field, invert, map back.
// ----------------------------------------------------------------------------
module gti_core import gti_pkg::*; (
  input  wire logic [7:0] value,
  output logic      [7:0] inverse
);

  logic [7:0] tower;
  logic [7:0] tower_inv;

  // Basis change in, tower inversion, basis change out
  assign tower     = map_basis(value, TO_TOWER);
  assign tower_inv = inv256(tower);
  assign inverse   = map_basis(tower_inv, FROM_TOWER);

endmodule
`default_nettype wire

// ----- hdl/gf256_tower_field_inverse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_tower_field_inverse
// Multiplicative inverse in GF(2^8) (AES polynomial basis), zero to zero.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the output is not stalled and returns its inverse
// through one input register and one result register, with the composite-field
// XOR/AND network between them. A stall on the output holds both registers, and
// a new byte is still taken while the input register is empty or moving forward
// in the same cycle.
// ----------------------------------------------------------------------------
module gf256_tower_field_inverse import gti_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  gti_in_if.sink    in_ch,
  gti_out_if.source out_ch
);

  logic       s1_valid;
  logic [7:0] s1_value;
  logic       out_valid;
  logic [7:0] out_data;
  logic [7:0] inv_comb;
  logic       s1_adv;

  // Pipeline flow control
  assign s1_adv      = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_value <= in_ch.value_in;
    end
  end

  gti_core u_core (
    .value   (s1_value),
    .inverse (inv_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && s1_adv) begin
      out_data <= inv_comb;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.inverse_out = out_data;

  // Assertions
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> (out_valid && out_data == $past(inv_comb)))
    else $error("result register missed a transfer");

  a_zero_map: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_value == 8'h00) |-> inv_comb == 8'h00)
    else $error("zero did not map to zero");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ch.ready)
    else $error("input stalled with empty input register");

endmodule
`default_nettype wire

// ----- verif/gti_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gti_tb_pkg
// Expected-inverse tracking for the tower-field inverter bench: an
// independent composite-field model and an in-order store of pending bytes.
// ----------------------------------------------------------------------------
package gti_tb_pkg;

  typedef bit [7:0] basis_rows_t [8];

  // Basis change rows, row r at index r; bit k of an operand picks row 7-k
  localparam basis_rows_t INTO_TOWER = '{
    8'h98, 8'hf3, 8'hf2, 8'h48, 8'h09, 8'h81, 8'ha9, 8'hff
  };
  localparam basis_rows_t OUT_OF_TOWER = '{
    8'h64, 8'h78, 8'h6e, 8'h8c, 8'h68, 8'h29, 8'hde, 8'h60
  };

  // Extension coefficients: GF(16) over GF(4), GF(256) over GF(16)
  localparam bit [1:0] NU   = 2'h2;
  localparam bit [3:0] LAMB = 4'h1;

  typedef struct packed {
    bit [7:0] operand;
    bit [7:0] inverse;
  } pending_inverse_t;

  class inverse_scoreboard;
    pending_inverse_t pending_q[$];
    int unsigned      mismatches;
    int unsigned      matched;
    int unsigned      accepted;
    bit [255:0]       operands_seen;

    // Linear basis change: XOR of the rows picked by the set bits
    function bit [7:0] change_basis(bit [7:0] v, basis_rows_t rows);
      bit [7:0] acc;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
        if (v[k]) acc ^= rows[7 - k];
      end
      return acc;
    endfunction

    // GF(4) product, normal basis
    function bit [1:0] gf4_prod(bit [1:0] x, bit [1:0] y);
      bit mix;
      mix = (x[1] ^ x[0]) & (y[1] ^ y[0]);
      return {(x[1] & y[1]) ^ mix, (x[0] & y[0]) ^ mix};
    endfunction

    // GF(16) product over GF(4)
    function bit [3:0] gf16_prod(bit [3:0] x, bit [3:0] y);
      bit [1:0] mix;
      mix = gf4_prod(gf4_prod(x[3:2] ^ x[1:0], y[3:2] ^ y[1:0]), NU);
      return {gf4_prod(x[3:2], y[3:2]) ^ mix, gf4_prod(x[1:0], y[1:0]) ^ mix};
    endfunction

    // GF(16) reciprocal; in GF(4) the reciprocal is the square
    function bit [3:0] gf16_recip(bit [3:0] x);
      bit [1:0] hsum;
      bit [1:0] norm;
      bit [1:0] norm_inv;
      hsum     = x[3:2] ^ x[1:0];
      norm     = gf4_prod(gf4_prod(hsum, hsum), NU) ^ gf4_prod(x[3:2], x[1:0]);
      norm_inv = gf4_prod(norm, norm);
      return {gf4_prod(norm_inv, x[1:0]), gf4_prod(norm_inv, x[3:2])};
    endfunction

    // GF(256) reciprocal over GF(16)
    function bit [7:0] tower_recip(bit [7:0] x);
      bit [3:0] hsum;
      bit [3:0] norm_inv;
      hsum     = x[7:4] ^ x[3:0];
      norm_inv = gf16_recip(gf16_prod(gf16_prod(hsum, hsum), LAMB) ^
                            gf16_prod(x[7:4], x[3:0]));
      return {gf16_prod(norm_inv, x[3:0]), gf16_prod(norm_inv, x[7:4])};
    endfunction

    function bit [7:0] field_inverse(bit [7:0] v);
      return change_basis(tower_recip(change_basis(v, INTO_TOWER)), OUT_OF_TOWER);
    endfunction

    function void note_operand(bit [7:0] v);
      pending_inverse_t p;
      p.operand = v;
      p.inverse = field_inverse(v);
      pending_q.push_back(p);
      operands_seen[v] = 1'b1;
      accepted++;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Results come back in order: compare with the oldest pending byte
    task check_inverse(bit [7:0] got);
      pending_inverse_t p;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("inverse_out 0x%02h with no byte outstanding", got));
      end else begin
        p = pending_q.pop_front();
        if (got !== p.inverse)
          report_mismatch($sformatf("inverse of 0x%02h: got 0x%02h, want 0x%02h",
                                    p.operand, got, p.inverse));
        else
          matched++;
      end
    endtask

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    function int unsigned distinct_operands();
      return $countones(operands_seen);
    endfunction
  endclass

endpackage

// ----- verif/gf256_tower_field_inverse_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_tower_field_inverse_tb
// Streams bytes into the inverter with random idle and back-pressure bursts
// and checks every returned inverse, in order, against an independent
// composite-field model held in the scoreboard.
// ----------------------------------------------------------------------------
module gf256_tower_field_inverse_tb;
  import gti_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_BLOCKS  = 12;
  localparam int unsigned BLOCK_ITEMS  = 50;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Zero, the unit, single bits, all-ones, a few known AES pairs and patterns
  localparam bit [7:0] CORNER_BYTES [23] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hff, 8'hfe, 8'h7f, 8'h53, 8'hca, 8'h1b, 8'h8d, 8'haa, 8'h55, 8'h0f,
    8'hf0, 8'he5, 8'h11
  };

  logic clk;
  logic rst;
  bit   quiet;
  int   stall_left;
  int unsigned cycles;

  inverse_scoreboard sb;

  gti_in_if  in_ch ();
  gti_out_if out_ch ();

  gf256_tower_field_inverse dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d inverses outstanding",
               cycles, sb.outstanding());
      $display("gf256_tower_field_inverse regression: fail");
      $finish;
    end
  end

  // Transfer monitor: note accepted bytes, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_operand(in_ch.value_in);
      if (out_ch.valid && out_ch.ready) sb.check_inverse(out_ch.inverse_out);
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ch.ready <= !rst;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // One byte per call, with an optional idle burst in front of it
  task automatic send_byte(input bit [7:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    rst            = 1'b1;
    quiet          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value_in = '0;
    sb             = new();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    foreach (CORNER_BYTES[i]) send_byte(CORNER_BYTES[i]);

    // Random bytes; some blocks run with no idling at all
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat (BLOCK_ITEMS) send_byte(8'($urandom_range(0, 255)));
    end

    // Closing stretch at full rate on both sides
    quiet = 1'b1;
    repeat (TAIL_ITEMS) send_byte(8'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d inverses matched, %0d of 256 operand values exercised",
             sb.accepted, sb.matched, sb.distinct_operands());
    $display("%0d mismatches over %0d cycles", sb.mismatches, cycles);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("gf256_tower_field_inverse regression: pass");
    end else begin
      $display("gf256_tower_field_inverse regression: fail");
    end
    $finish;
  end

endmodule
